// File: src/xrg_pkg.sv
`timescale 1ns / 1ps
// Package for the xorshift range generator: widths, register indexes,
// cell and divider control types. No dependencies.
package xrg_pkg;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned IndexWidth = 2;
   localparam int unsigned CntWidth   = 6;
   localparam int unsigned ShiftA     = 13;
   localparam int unsigned ShiftB     = 17;
   localparam int unsigned ShiftC     = 5;

   typedef logic [DataWidth-1:0]  word_type;
   typedef logic [IndexWidth-1:0] index_type;

   localparam index_type RegSeed = 2'd0;
   localparam index_type RegLow  = 2'd1;
   localparam index_type RegHigh = 2'd2;

   localparam word_type SeedReset = 32'd1;
   localparam word_type LowReset  = 32'd0;
   localparam word_type HighReset = 32'hFFFF_FFFF;

   // control handed along the divider row
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   function automatic word_type advance(input word_type s);
      word_type t;
      t = s ^ (s << ShiftA);
      t = t ^ (t >> ShiftB);
      t = t ^ (t << ShiftC);
      return t;
   endfunction
endpackage

// File: src/xrg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request, response and register writes.
// Depends on xrg_pkg.
interface xrg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface xrg_rsp_if;
   logic                valid;
   logic                ready;
   xrg_pkg::word_type   ranged_value;
   xrg_pkg::word_type   raw_state;
   modport source (output valid, output ranged_value, output raw_state, input ready);
   modport sink   (input valid, input ranged_value, input raw_state, output ready);
endinterface

interface xrg_csr_if;
   logic                valid;
   logic                ready;
   xrg_pkg::index_type  index;
   xrg_pkg::word_type   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/xrg_cell.sv
`timescale 1ns / 1ps
// One bit cell of the restoring divider row: holds one remainder and one
// quotient bit, takes its neighbour's bits each step. Depends on xrg_pkg.
module xrg_cell (
   input  logic                   clock,
   input  xrg_pkg::cell_ctrl_type ctrl,
   input  logic                   load_bit,
   input  logic                   rem_lower,
   input  logic                   rem_new,
   input  logic                   quo_lower,
   input  logic                   take,
   output logic                   rem_out,
   output logic                   quo_out
);
   logic rem_ff, rem_in;
   logic quo_ff, quo_in;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         rem_in = 1'b0;
         quo_in = load_bit;
      end else if (ctrl.shift) begin
         rem_in = take ? rem_new : rem_lower;
         quo_in = quo_lower;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
endmodule

// File: src/xrg_div_row.sv
`timescale 1ns / 1ps
// Row of bit cells forming a 32-step restoring remainder unit.
// Depends on xrg_pkg and xrg_cell.
module xrg_div_row (
   input  logic                   clock,
   input  xrg_pkg::cell_ctrl_type ctrl,
   input  xrg_pkg::word_type      dividend,
   input  xrg_pkg::word_type      divisor,
   output xrg_pkg::word_type      remainder
);
   localparam int unsigned W = xrg_pkg::DataWidth;

   logic [W-1:0] rem_q, quo_q;
   logic [W:0]   trial;
   logic [W:0]   diff;
   logic         take;

   assign trial = {rem_q, quo_q[W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign take  = ~diff[W];

   for (genvar i = 0; i < W; i++) begin : g_cell
      xrg_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_bit  (dividend[i]),
         .rem_lower (trial[i]),
         .rem_new   (diff[i]),
         .quo_lower ((i == 0) ? 1'b0 : quo_q[(i == 0) ? 0 : i-1]),
         .take      (take),
         .rem_out   (rem_q[i]),
         .quo_out   (quo_q[i])
      );
   end

   assign remainder = rem_q;
endmodule

// File: src/xorshift_range_generator.sv
`timescale 1ns / 1ps
// Top level of the xorshift range generator.
// Depends on xrg_pkg, xrg_if and xrg_div_row.
//
// Use: each request transfer on req_ (restart bit) steps a 32-bit xorshift32
// state, first reloading it from the seed register when restart is set. One
// response transfer on rsp_ follows per request, carrying the new state and
// range_low + state mod span, span = range_high - range_low + 1 (mod 2^32).
// A span of zero means the full range and skips the divider.
// csr_ writes register index 0 seed, 1 range_low, 2 range_high; other
// indexes are dropped. Write only while idle.
// From a request transfer: the state steps on the transfer edge, then the
// bit-cell row loads, takes 32 divider steps and the finish stage writes
// the output register; for full range the load state writes it directly.
// A new request is taken only once the previous one has left for the output register.
// Reset restores seed 1, range 0..0xFFFFFFFF and state 1, clears the
// sequencer; no clearing pass. If the receiver stalls, the result is held
// in the output register; one further request is taken and waits in the finish
// stage (load state if full range), then requests stall until the register frees.
module xorshift_range_generator (
   input logic         clock,
   input logic         reset,
   xrg_req_if.sink     req,
   xrg_rsp_if.source   rsp,
   xrg_csr_if.sink     csr
);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StLoad = 2'd1;
   localparam logic [1:0] StDiv  = 2'd2;
   localparam logic [1:0] StOut  = 2'd3;
   localparam logic [xrg_pkg::CntWidth-1:0] LastStep =
      xrg_pkg::CntWidth'(xrg_pkg::DataWidth - 1);

   xrg_pkg::word_type seed_ff, low_ff, high_ff, state_ff, state_in;
   xrg_pkg::word_type span_ff, span_in, value_ff, value_in, remainder;
   xrg_pkg::word_type raw_ff, raw_in;
   logic [1:0] st_ff, st_in;
   logic [xrg_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic valid_ff, valid_in;
   xrg_pkg::cell_ctrl_type ctrl;
   logic req_xfer, rsp_xfer, out_free;
   xrg_pkg::word_type next_state;

   assign req.ready = (st_ff == StIdle);
   assign csr.ready = 1'b1;
   assign req_xfer  = req.valid && req.ready;
   assign rsp_xfer  = rsp.valid && rsp.ready;
   assign out_free  = !valid_ff || rsp_xfer;
   assign next_state = xrg_pkg::advance(req.restart ? seed_ff : state_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= xrg_pkg::SeedReset;
         low_ff  <= xrg_pkg::LowReset;
         high_ff <= xrg_pkg::HighReset;
      end else if (csr.valid) begin
         unique case (csr.index)
            xrg_pkg::RegSeed: seed_ff <= csr.data;
            xrg_pkg::RegLow:  low_ff  <= csr.data;
            xrg_pkg::RegHigh: high_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      state_in = state_ff;
      span_in  = span_ff;
      value_in = value_ff;
      raw_in   = raw_ff;
      valid_in = valid_ff && !rsp_xfer;
      ctrl     = '0;
      unique case (st_ff)
         StIdle: begin
            if (req_xfer) begin
               state_in = next_state;
               span_in  = high_ff - low_ff + 32'd1;
               st_in    = StLoad;
            end
         end
         StLoad: begin
            if (span_ff == '0) begin
               if (out_free) begin
                  value_in = low_ff + state_ff;
                  raw_in   = state_ff;
                  valid_in = 1'b1;
                  st_in    = StIdle;
               end
            end else begin
               ctrl.load = 1'b1;
               cnt_in    = '0;
               st_in     = StDiv;
            end
         end
         StDiv: begin
            ctrl.shift = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) st_in = StOut;
         end
         StOut: begin
            if (out_free) begin
               value_in = low_ff + remainder;
               raw_in   = state_ff;
               valid_in = 1'b1;
               st_in    = StIdle;
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= StIdle;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         state_ff <= xrg_pkg::SeedReset;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff  <= span_in;
      value_ff <= value_in;
      raw_ff   <= raw_in;
   end

   xrg_div_row u_div (
      .clock     (clock),
      .ctrl      (ctrl),
      .dividend  (state_ff),
      .divisor   (span_ff),
      .remainder (remainder)
   );

   assign rsp.valid        = valid_ff;
   assign rsp.ranged_value = value_ff;
   assign rsp.raw_state    = raw_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != StIdle |-> !req.ready) else $error("request taken while busy");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.raw_state))
      else $error("response lost under stall");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      st_ff == StDiv && cnt_ff == LastStep |=> st_ff == StOut)
      else $error("divider step count wrong");
   a_zero_stays: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req.restart && state_ff == '0 |=> state_ff == '0)
      else $error("zero state left zero");
endmodule
